FILE: design/pve_pkg.sv
`timescale 1ns / 1ps
package pve_pkg;

  localparam int CordicSteps = 30;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      5'd24: v = 32'sd41;
      5'd25: v = 32'sd20;
      5'd26: v = 32'sd10;
      5'd27: v = 32'sd5;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  typedef enum logic [3:0] {
    REG_MIN_INTERVAL = 4'd0,
    REG_MAX_INTERVAL = 4'd1,
    REG_SPEED_LIMIT  = 4'd2,
    REG_FILTER_TAU   = 4'd3
  } reg_index_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch input item
    OP_DT,        // dt and range check
    OP_DIV_VX,    // start divider on x
    OP_DIV_VY,    // store vx, start divider on y
    OP_VY_DONE,   // store vy
    OP_SQ,        // speed squares
    OP_SPEED,     // speed compare
    OP_CORDIC,    // start cordic
    OP_ROT,       // body rotation products
    OP_ROT_SUM,   // round and saturate
    OP_FILT_F,    // start filter divide, forward
    OP_FILT_S,    // store forward, start side
    OP_FILT_END,  // store side
    OP_FINISH     // write result and state
  } op_t;

  typedef struct packed {
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic sample_ok;
    logic have_base;
    logic have_filtered;
    logic tau_zero;
    logic dt_bad;
    logic speed_bad;
    logic unit_busy;
  } dp_status_t;

endpackage

FILE: design/pve_divider.sv
`timescale 1ns / 1ps
module pve_divider import pve_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [95:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [95:0] quo
);

  logic [6:0]  cnt;
  logic [64:0] rem;
  logic [95:0] q;
  logic [63:0] d;
  logic [64:0] trial;

  assign trial = {rem[63:0], q[95]} - {1'b0, d};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd96;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      d   <= den;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial;
        q   <= {q[94:0], 1'b1};
      end else begin
        rem <= {rem[63:0], q[95]};
        q   <= {q[94:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/pve_cordic.sv
`timescale 1ns / 1ps
module pve_cordic import pve_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] heading,
  output logic               busy,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_q,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_q
);

  localparam int Sh = 30 - TRIG_FRAC_BITS;
  localparam logic signed [33:0] One = 34'sd1 <<< TRIG_FRAC_BITS;

  logic [4:0] step;
  logic signed [33:0] x, y, z;
  logic neg;
  logic [31:0] ang;
  logic signed [33:0] rx, ry;

  assign ang = {heading, 16'd0};

  function automatic logic signed [TRIG_FRAC_BITS+1:0] rnd(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + (34'sd1 <<< (Sh - 1))) >>> Sh;
    if (r > One) r = One;
    if (r < -One) r = -One;
    return r[TRIG_FRAC_BITS+1:0];
  endfunction

  assign rx = neg ? -x : x;
  assign ry = neg ? -y : y;
  assign cos_q = rnd(rx);
  assign sin_q = rnd(ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 5'd1;
      if (step == 5'(CordicSteps - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= 34'sd652032874;
      y <= '0;
      if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
        neg <= 1'b1;
        z   <= 34'(signed'(ang - 32'h8000_0000));
      end else begin
        neg <= 1'b0;
        z   <= 34'(signed'(ang));
      end
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - 34'(atan_entry(step));
      end else begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + 34'(atan_entry(step));
      end
    end
  end

endmodule

FILE: design/pve_datapath.sv
`timescale 1ns / 1ps
module pve_datapath import pve_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               kind,
  input  logic               sample_ok,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [47:0]        stamp_us,
  input  logic signed [15:0] heading,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               estimate_valid,
  output logic signed [31:0] vel_forward,
  output logic signed [31:0] vel_side
);

  localparam int Tw = TRIG_FRAC_BITS + 2;

  logic [31:0] min_iv, max_iv, tau;
  logic [30:0] lim;
  logic signed [31:0] base_x, base_y, filt_f, filt_s;
  logic [47:0] base_stamp;
  logic have_base, have_filtered;

  logic l_kind, l_ok;
  logic signed [31:0] l_x, l_y;
  logic [47:0] l_t;
  logic signed [15:0] l_h;

  logic [47:0] dt;
  logic dt_bad, speed_bad;
  logic signed [32:0] dx, dy;
  logic signed [31:0] vx, vy;
  logic [63:0] sqx, sqy;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [31:0] fwd, side;

  logic div_start, div_busy;
  logic [95:0] div_num, div_quo;
  logic [63:0] div_den;
  logic div_neg;
  logic cor_start, cor_busy;
  logic signed [Tw-1:0] cos_q, sin_q;

  pve_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  pve_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .heading(l_h),
    .busy(cor_busy), .cos_q(cos_q), .sin_q(sin_q)
  );

  // signed quotient with half-away rounding, saturated to 32 bits
  function automatic logic signed [32:0] sdiv_result(input logic [95:0] q, input logic n);
    logic ovf;
    logic signed [32:0] r;
    ovf = |q[95:31];
    if (n) r = (ovf || q[30:0] == 31'd0 && q[31]) ? -33'sd2147483648
                                                   : -$signed({2'b00, q[30:0]});
    else   r = ovf ? 33'sd2147483647 : $signed({2'b00, q[30:0]});
    if (n && q[95:31] == 65'd1) r = -33'sd2147483648;
    return r;
  endfunction

  // overflow flag for velocity
  function automatic logic vsat(input logic [95:0] q, input logic n);
    return n ? (q > 96'd2147483648) : (q > 96'd2147483647);
  endfunction

  function automatic logic signed [31:0] rot(input logic signed [64:0] v);
    logic signed [64:0] r;
    r = (v + (65'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (r > 65'sd2147483647) r = 65'sd2147483647;
    if (r < -65'sd2147483648) r = -65'sd2147483648;
    return r[31:0];
  endfunction

  logic signed [32:0] diff_cur;
  logic [32:0] mag_cur;
  logic signed [32:0] qv;
  logic [48:0] den_f;

  assign diff_cur = (cmd.op == OP_FILT_F) ? 33'(fwd) - 33'(filt_f)
                                         : 33'(side) - 33'(filt_s);
  assign mag_cur  = diff_cur[32] ? 33'(-diff_cur) : 33'(diff_cur);
  assign den_f    = 49'(tau) + 49'(dt);
  assign qv       = div_neg ? -$signed({1'b0, div_quo[31:0]}) : $signed({1'b0, div_quo[31:0]});

  function automatic logic signed [31:0] addsat(input logic signed [31:0] f,
                                                input logic signed [32:0] d);
    logic signed [33:0] s;
    s = 34'(f) + 34'(d);
    if (s > 34'sd2147483647) s = 34'sd2147483647;
    if (s < -34'sd2147483648) s = -34'sd2147483648;
    return s[31:0];
  endfunction

  logic [47:0] dts;
  assign dts = l_t - base_stamp;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 64'(dt);
    cor_start = 1'b0;
    case (cmd.op)
      OP_DIV_VX: begin
        div_start = 1'b1;
        div_num = 96'((dx[32] ? 33'(-dx) : 33'(dx)) * 96'd64000000) + 96'(dt >> 1);
      end
      OP_DIV_VY: begin
        div_start = 1'b1;
        div_num = 96'((dy[32] ? 33'(-dy) : 33'(dy)) * 96'd64000000) + 96'(dt >> 1);
      end
      OP_FILT_F, OP_FILT_S: begin
        // difference magnitude and dt both fit 32 bits here
        div_start = 1'b1;
        div_num = 96'(64'(mag_cur[31:0]) * 64'(dt[31:0])) + 96'(den_f >> 1);
        div_den = 64'(den_f);
      end
      OP_CORDIC: cor_start = 1'b1;
      default: ;
    endcase
  end

  assign status.kind = l_kind;
  assign status.sample_ok = l_ok;
  assign status.have_base = have_base;
  assign status.have_filtered = have_filtered;
  assign status.tau_zero = (tau == 32'd0);
  assign status.dt_bad = dt_bad;
  assign status.speed_bad = speed_bad;
  assign status.unit_busy = div_busy | cor_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_iv <= 32'd1000;
      max_iv <= 32'd1000000;
      lim    <= 31'd6553600;
      tau    <= 32'd100000;
    end else if (cfg_we) begin
      case (cfg_index)
        2'(REG_MIN_INTERVAL): min_iv <= cfg_data;
        2'(REG_MAX_INTERVAL): max_iv <= cfg_data;
        2'(REG_SPEED_LIMIT):  lim    <= cfg_data[30:0];
        2'(REG_FILTER_TAU):   tau    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_base <= 1'b0;
      have_filtered <= 1'b0;
      filt_f <= '0;
      filt_s <= '0;
      base_x <= '0;
      base_y <= '0;
      base_stamp <= '0;
      estimate_valid <= 1'b0;
      vel_forward <= '0;
      vel_side <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          l_kind <= kind; l_ok <= sample_ok; l_x <= pos_x; l_y <= pos_y;
          l_t <= stamp_us; l_h <= heading;
        end
        OP_DT: begin
          dt <= dts;
          dt_bad <= (l_t <= base_stamp) || (dts < 48'(min_iv)) || (dts > 48'(max_iv));
          dx <= 33'(l_x) - 33'(base_x);
          dy <= 33'(l_y) - 33'(base_y);
          speed_bad <= 1'b0;
        end
        OP_DIV_VX: div_neg <= dx[32];
        OP_DIV_VY: begin
          vx <= 32'(sdiv_result(div_quo, div_neg));
          speed_bad <= vsat(div_quo, div_neg);
          div_neg <= dy[32];
        end
        OP_VY_DONE: begin
          vy <= 32'(sdiv_result(div_quo, div_neg));
          if (vsat(div_quo, div_neg)) speed_bad <= 1'b1;
        end
        OP_SQ: begin
          sqx <= 64'(vx) * 64'(vx);
          sqy <= 64'(vy) * 64'(vy);
        end
        OP_SPEED: if (65'(sqx) + 65'(sqy) > 65'(64'(lim) * 64'(lim))) speed_bad <= 1'b1;
        OP_ROT: begin
          p0 <= 64'(cos_q) * 64'(vx);
          p1 <= 64'(sin_q) * 64'(vy);
          p2 <= 64'(cos_q) * 64'(vy);
          p3 <= 64'(sin_q) * 64'(vx);
        end
        OP_ROT_SUM: begin
          fwd  <= rot(65'(p0) + 65'(p1));
          side <= rot(65'(p2) - 65'(p3));
        end
        OP_FILT_F: div_neg <= diff_cur[32];
        OP_FILT_S: begin
          filt_f <= addsat(filt_f, qv);
          div_neg <= diff_cur[32];
        end
        OP_FILT_END: filt_s <= addsat(filt_s, qv);
        OP_FINISH: begin
          estimate_valid <= 1'b0;
          vel_forward <= '0;
          vel_side <= '0;
          if (l_kind) begin
            have_base <= 1'b0;
            have_filtered <= 1'b0; filt_f <= '0; filt_s <= '0;
          end else if (!l_ok) begin
            have_filtered <= 1'b0; filt_f <= '0; filt_s <= '0;
          end else begin
            base_x <= l_x; base_y <= l_y; base_stamp <= l_t; have_base <= 1'b1;
            if (!have_base || dt_bad || speed_bad) begin
              have_filtered <= 1'b0; filt_f <= '0; filt_s <= '0;
            end else begin
              have_filtered <= 1'b1;
              estimate_valid <= 1'b1;
              if (!have_filtered || tau == 32'd0) begin
                filt_f <= fwd; filt_s <= side;
                vel_forward <= fwd; vel_side <= side;
              end else begin
                vel_forward <= filt_f; vel_side <= filt_s;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/pve_control.sv
`timescale 1ns / 1ps
module pve_control import pve_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DT     = 13'b0000000000010,
    S_DX     = 13'b0000000000100,
    S_WX     = 13'b0000000001000,
    S_WY     = 13'b0000000010000,
    S_SQ     = 13'b0000000100000,
    S_SPEED  = 13'b0000001000000,
    S_COR    = 13'b0000010000000,
    S_WCOR   = 13'b0000100000000,
    S_ROT    = 13'b0001000000000,
    S_SUM    = 13'b0010000000000,
    S_FILT   = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   second, second_next;
  logic   out_valid_next;
  logic   fire;

  // next request may enter only when no result waits or it is taken now, one item in flight
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    second_next = second;
    out_valid_next = out_valid && !out_ready;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: if (fire) begin
        cmd.op = OP_LOAD;
        state_next = S_DT;
      end
      S_DT: begin
        if (status.kind || !status.sample_ok || !status.have_base) begin
          state_next = S_FIN;
        end else begin
          cmd.op = OP_DT;
          state_next = S_DX;
        end
      end
      S_DX: begin
        if (status.dt_bad) state_next = S_FIN;
        else begin
          cmd.op = OP_DIV_VX;
          state_next = S_WX;
        end
      end
      S_WX: if (!status.unit_busy) begin
        cmd.op = OP_DIV_VY;
        state_next = S_WY;
      end
      S_WY: if (!status.unit_busy) begin
        cmd.op = OP_VY_DONE;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        state_next = S_SPEED;
      end
      S_SPEED: begin
        cmd.op = OP_SPEED;
        state_next = S_COR;
      end
      S_COR: begin
        if (status.speed_bad) state_next = S_FIN;
        else begin
          cmd.op = OP_CORDIC;
          state_next = S_WCOR;
        end
      end
      S_WCOR: if (!status.unit_busy) begin
        cmd.op = OP_ROT;
        state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT_SUM;
        state_next = S_SUM;
      end
      S_SUM: begin
        if (!status.have_filtered || status.tau_zero) state_next = S_FIN;
        else begin
          cmd.op = OP_FILT_F;
          second_next = 1'b0;
          state_next = S_FILT;
        end
      end
      S_FILT: if (!status.unit_busy) begin
        if (!second) begin
          cmd.op = OP_FILT_S;
          second_next = 1'b1;
        end else begin
          cmd.op = OP_FILT_END;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op = OP_FINISH;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      second <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      second <= second_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: design/pose_velocity_estimator.sv
`timescale 1ns / 1ps
// Position/velocity estimator. One request at a time. A restart, an invalid
// sample or a sample with no baseline goes straight to the finish step. An
// interval reject ends after the interval check and a speed reject after the
// speed check. A full estimate also runs the low pass when a filtered value
// exists and tau is nonzero. The velocity path uses two bit-serial divides and
// the filter uses two more, all on one shared divider. There are also 30
// CORDIC iterations and a few fixed steps. The state machine returns to its
// idle state, where the next request is taken. A finished result is held in the
// output register until it is taken; the next request may enter in that cycle.
module pose_velocity_estimator import pve_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic               sample_ok,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [47:0]        stamp_us,
  input  logic signed [15:0] heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               estimate_valid,
  output logic signed [31:0] vel_forward,
  output logic signed [31:0] vel_side,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pve_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .status(status)
  );

  pve_datapath #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .kind(kind), .sample_ok(sample_ok), .pos_x(pos_x), .pos_y(pos_y),
    .stamp_us(stamp_us), .heading(heading),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .estimate_valid(estimate_valid), .vel_forward(vel_forward), .vel_side(vel_side)
  );

endmodule

FILE: verif/pose_velocity_estimator_tb.sv
`timescale 1ns / 1ps
module pose_velocity_estimator_tb;
  import pve_pkg::*;

  localparam int FracBits = 15;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic               ev;
    logic signed [31:0] fwd;
    logic signed [31:0] side;
  } estimate_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic               sample_ok = 1'b0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic [47:0]        stamp_us = '0;
  logic signed [15:0] heading = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               estimate_valid;
  logic signed [31:0] vel_forward;
  logic signed [31:0] vel_side;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  pose_velocity_estimator #(.TRIG_FRAC_BITS(FracBits)) u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block
  logic [31:0]        m_min, m_max, m_tau;
  logic [30:0]        m_lim;
  logic signed [31:0] m_bx, m_by, m_ff, m_fs;
  logic [47:0]        m_bt;
  logic               m_hb, m_hf;

  estimate_t est_q[$];
  int        err_cnt = 0;
  int        idle_cnt = 0;
  bit        rx_hold = 1'b0;
  bit        no_idle = 1'b0;
  logic [47:0]        cur_t = '0;
  logic signed [31:0] cur_x = '0, cur_y = '0;

  longint atan_q30[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  function automatic longint clamp32(longint v, inout bit hit);
    if (v > 64'sd2147483647) begin hit = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin hit = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint trig_round(longint q30);
    longint one, r;
    one = 64'sd1 <<< FracBits;
    r = (q30 + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r;
  endfunction

  function automatic void yaw_cos_sin(logic signed [15:0] h, output longint c,
                                      output longint s);
    logic [31:0] a;
    bit neg;
    longint x, y, z, dx, dy;
    a = {h, 16'h0};
    neg = 0;
    if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
      a = a - 32'h8000_0000;
      neg = 1;
    end
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30[i];
      end else begin
        x += dx; y -= dy; z += atan_q30[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = trig_round(x);
    s = trig_round(y);
  endfunction

  function automatic logic signed [31:0] low_pass(logic signed [31:0] f, longint raw,
                                                  longint unsigned dt);
    longint diff, delta;
    logic [127:0] mag, den, q;
    bit dummy;
    dummy = 0;
    diff = raw - longint'(f);
    mag = (diff < 0) ? 128'(-diff) : 128'(diff);
    den = 128'(m_tau) + 128'(dt);
    q = (mag * 128'(dt) + den / 2) / den;
    delta = (diff < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    return 32'(clamp32(longint'(f) + delta, dummy));
  endfunction

  function automatic void rebase(logic signed [31:0] x, logic signed [31:0] y,
                                 logic [47:0] t);
    m_bx = x; m_by = y; m_bt = t; m_hb = 1;
  endfunction

  function automatic estimate_t predict_estimate(logic k, logic ok, logic signed [31:0] x,
                                                 logic signed [31:0] y, logic [47:0] t,
                                                 logic signed [15:0] h);
    estimate_t e;
    longint dts, vx, vy, c, s, fwd, side;
    longint unsigned dt, lim2;
    bit sat, dummy;
    e = '{1'b0, 32'sd0, 32'sd0};
    sat = 0;
    dummy = 0;
    if (k) begin
      m_hb = 0; m_hf = 0; m_ff = 0; m_fs = 0;
      return e;
    end
    if (!ok || !m_hb) begin
      if (ok) rebase(x, y, t);
      m_hf = 0; m_ff = 0; m_fs = 0;
      return e;
    end
    dts = longint'({16'h0, t}) - longint'({16'h0, m_bt});
    if (dts <= 0 || dts < longint'({32'h0, m_min}) || dts > longint'({32'h0, m_max})) begin
      rebase(x, y, t);
      m_hf = 0; m_ff = 0; m_fs = 0;
      return e;
    end
    dt = dts;
    vx = clamp32(round_div((longint'(x) - longint'(m_bx)) * 64000000, dt), sat);
    vy = clamp32(round_div((longint'(y) - longint'(m_by)) * 64000000, dt), sat);
    lim2 = longint'(m_lim) * longint'(m_lim);
    if (sat || longint'(vx * vx) + longint'(vy * vy) > lim2) begin
      rebase(x, y, t);
      m_hf = 0; m_ff = 0; m_fs = 0;
      return e;
    end
    yaw_cos_sin(h, c, s);
    fwd = clamp32((c * vx + s * vy + (64'sd1 <<< (FracBits - 1))) >>> FracBits, dummy);
    side = clamp32((c * vy - s * vx + (64'sd1 <<< (FracBits - 1))) >>> FracBits, dummy);
    if (!m_hf || m_tau == 0) begin
      m_ff = 32'(fwd); m_fs = 32'(side); m_hf = 1;
    end else begin
      m_ff = low_pass(m_ff, fwd, dt);
      m_fs = low_pass(m_fs, side, dt);
    end
    rebase(x, y, t);
    e = '{1'b1, m_ff, m_fs};
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    estimate_t e;
    if (!rst && out_valid && out_ready) begin
      if (est_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = est_q.pop_front();
        if (estimate_valid !== e.ev) report_mismatch("estimate_valid", estimate_valid, e.ev);
        if (vel_forward !== e.fwd) report_mismatch("vel_forward", vel_forward, e.fwd);
        if (vel_side !== e.side) report_mismatch("vel_side", vel_side, e.side);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver with random stalls
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 18);
      if (n > 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
        while (rx_hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic k, logic ok, logic signed [31:0] x,
                              logic signed [31:0] y, logic [47:0] t, logic signed [15:0] h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind <= k; sample_ok <= ok; pos_x <= x; pos_y <= y; stamp_us <= t; heading <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    est_q.push_back(predict_estimate(k, ok, x, y, t, h));
    @(negedge clk);
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (est_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx[1:0]; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_INTERVAL: m_min = v;
      REG_MAX_INTERVAL: m_max = v;
      REG_SPEED_LIMIT:  m_lim = v[30:0];
      REG_FILTER_TAU:   m_tau = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] mn, logic [31:0] mx, logic [31:0] lim,
                          logic [31:0] tau);
    drain();
    write_reg(REG_MIN_INTERVAL, mn);
    write_reg(REG_MAX_INTERVAL, mx);
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_FILTER_TAU, tau);
  endtask

  // next sample of a plausible track, sometimes spoiled
  task automatic track_request(logic [31:0] dt_lo, logic [31:0] dt_hi);
    int mode;
    longint unsigned dt;
    longint step;
    logic signed [15:0] h;
    mode = $urandom_range(0, 99);
    h = 16'($urandom);
    if (mode < 4) begin
      send_request(1'b1, 1'($urandom), $urandom, $urandom, {$urandom, $urandom}, h);
    end else if (mode < 8) begin
      send_request(1'b0, 1'b0, $urandom, $urandom, {$urandom, $urandom}, h);
    end else if (mode < 12) begin
      cur_x = $urandom; cur_y = $urandom; cur_t = {$urandom, $urandom};
      send_request(1'b0, 1'b1, cur_x, cur_y, cur_t, h);
    end else begin
      dt = (mode < 16) ? $urandom_range(0, 32'hFFFF_FFFF) : $urandom_range(dt_lo, dt_hi);
      cur_t = cur_t + 48'(dt);
      step = longint'(m_lim) * longint'(dt) / 64000000;
      if (mode < 20) step = step * 2 + 1;
      if (step > 64'sd1073741823) step = 64'sd1073741823;
      cur_x = cur_x + 32'(longint'($urandom_range(0, 32'(2 * step))) - step);
      cur_y = cur_y + 32'(longint'($urandom_range(0, 32'(step))) - step / 2);
      send_request(1'b0, 1'b1, cur_x, cur_y, cur_t, h);
    end
  endtask

  task automatic test_directed;
    logic signed [15:0] hs[5] = '{16'sd0, 16'sd16384, -16'sd32768, 16'sd32767, -16'sd16384};
    send_request(1'b1, 1'b1, 0, 0, 0, 0);
    send_request(1'b0, 1'b1, 1000, -1000, 48'd5000, 0);
    for (int i = 0; i < 5; i++)
      send_request(1'b0, 1'b1, 1000 + 600 * (i + 1), -1000 + 300 * i, 48'd5000 + 10000 * (i + 1),
                   hs[i]);
    send_request(1'b0, 1'b0, -1, -1, 48'hFFFF_FFFF_FFFF, 16'sd1);
    send_request(1'b0, 1'b1, 5000, -500, 48'd75000, 16'sd100);
    send_request(1'b0, 1'b1, 5000, -500, 48'd75000, 16'sd100);
    send_request(1'b0, 1'b1, 5100, -500, 48'd70000, 16'sd100);
    send_request(1'b0, 1'b1, 5200, -500, 48'd70500, 16'sd100);
    send_request(1'b0, 1'b1, 5300, -500, 48'd2000000, 16'sd100);
    send_request(1'b0, 1'b1, 50000, -500, 48'd2010000, 16'sd100);
    send_request(1'b0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 48'd2011000, 16'sd0);
    send_request(1'b0, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 48'd2012000, 16'sd0);
    send_request(1'b0, 1'b1, -1, 0, 48'hFFFF_FFFF_0000, 16'sh7FFF);
    send_request(1'b0, 1'b1, 0, 1, 48'hFFFF_FFFF_FFFF, 16'sh8000);
    send_request(1'b1, 1'b0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_register_extremes;
    set_regs(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_request(1'b0, 1'b1, 0, 0, 48'd0, 0);
    send_request(1'b0, 1'b1, 32'sh7FFF_FFFF, -32'sd2147483648, 48'd1, 16'sd8192);
    send_request(1'b0, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 48'hFFFF_FFFF, 16'sd8192);
    send_request(1'b0, 1'b1, 32'sh0, 32'sh0, 48'h1_FFFF_FFFE, -16'sd8192);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    send_request(1'b0, 1'b1, 0, 0, 48'hFFFF_FFFE, 0);
    send_request(1'b0, 1'b1, 0, 0, 48'h1_FFFF_FFFD, 0);
    send_request(1'b0, 1'b1, 1, 0, 48'h2_FFFF_FFFC, 0);
    drain();
  endtask

  task automatic test_pressure;
    set_regs(32'd1000, 32'd1000000, 32'd6553600, 32'd100000);
    no_idle = 1;
    rx_hold = 1;
    fork
      begin
        repeat (600) @(negedge clk);
        rx_hold = 0;
      end
    join_none
    repeat (8) track_request(32'd1000, 32'd30000);
    no_idle = 0;
    drain();
  endtask

  task automatic random_phase(int n, logic [31:0] mn, logic [31:0] mx, logic [31:0] lim,
                              logic [31:0] tau, logic [31:0] dt_lo, logic [31:0] dt_hi);
    set_regs(mn, mx, lim, tau);
    for (int i = 0; i < n; i++) begin
      no_idle = (i % 60) >= 45;
      track_request(dt_lo, dt_hi);
    end
    no_idle = 0;
  endtask

  task automatic test_random;
    random_phase(180, 32'd1000, 32'd1000000, 32'd6553600, 32'd100000, 32'd1000, 32'd50000);
    random_phase(170, 32'd1000, 32'd1000000, 32'd6553600, 32'd0, 32'd1000, 32'd50000);
    random_phase(170, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd5000, 32'd1, 32'd100000);
    random_phase(170, 32'd20, 32'd400, 32'd65536000, 32'hFFFF_FFFF, 32'd15, 32'd420);
    random_phase(170, 32'd10000, 32'd10000, 32'd100000, 32'd1, 32'd10000, 32'd10000);
    random_phase(170, 32'd500, 32'd200, 32'd3000000, 32'd20000, 32'd150, 32'd600);
    drain();
  endtask

  initial begin
    m_min = 32'd1000; m_max = 32'd1000000; m_lim = 31'd6553600; m_tau = 32'd100000;
    m_bx = 0; m_by = 0; m_bt = 0; m_hb = 0; m_hf = 0; m_ff = 0; m_fs = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    test_pressure();
    test_random();
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && est_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pve_pkg.sv
design/pve_divider.sv
design/pve_cordic.sv
design/pve_datapath.sv
design/pve_control.sv
design/pose_velocity_estimator.sv
verif/pose_velocity_estimator_tb.sv
